[src/wbc_pkg.sv]
// ----------------------------------------------------------------------------
// Word-break checker package
// Dictionary ROM contents, default sizes and the result record.
// ----------------------------------------------------------------------------
package wbc_pkg;

	localparam int MAX_WORD_LEN_DEF = 8;
	localparam int DICT_WORDS_DEF   = 13;

	// ROM geometry: entries and bytes per entry (text is padded with zeros)
	localparam int DICT_ROM_WORDS = 13;
	localparam int DICT_ROM_CHARS = 8;

	localparam int DICT_LEN [DICT_ROM_WORDS] = '{6, 7, 3, 4, 3, 5, 8, 3, 2, 1, 4, 3, 5};

	// first character at index 0
	localparam logic [7:0] DICT_TEXT [DICT_ROM_WORDS][DICT_ROM_CHARS] = '{
		'{8'h6d, 8'h6f, 8'h62, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00},
		'{8'h73, 8'h61, 8'h6d, 8'h73, 8'h75, 8'h6e, 8'h67, 8'h00},
		'{8'h73, 8'h61, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h73, 8'h75, 8'h6e, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h6d, 8'h61, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h6d, 8'h61, 8'h6e, 8'h67, 8'h6f, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h63, 8'h65, 8'h63, 8'h72, 8'h65, 8'h61, 8'h6d},
		'{8'h61, 8'h6e, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h67, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h6c, 8'h69, 8'h6b, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h63, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h63, 8'h72, 8'h65, 8'h61, 8'h6d, 8'h00, 8'h00, 8'h00}
	};

	// length of entry w, 0 for entries past the ROM
	function automatic int word_len(input int w);
		int len;
		len = 0;
		if (w >= 0 && w < DICT_ROM_WORDS) begin
			len = DICT_LEN[w];
		end
		return len;
	endfunction

	function automatic logic [7:0] word_char(input int w, input int t);
		logic [7:0] c;
		c = 8'h00;
		if (w >= 0 && w < DICT_ROM_WORDS && t >= 0 && t < DICT_ROM_CHARS) begin
			c = DICT_TEXT[w][t];
		end
		return c;
	endfunction

	typedef struct packed {
		logic splittable;
		logic at_end;
	} res_t;

endpackage

[src/wbc_fifo.sv]
// ----------------------------------------------------------------------------
// Two-entry queue
// Register-based FIFO; push and pop may both transfer in one cycle.
// ----------------------------------------------------------------------------
module wbc_fifo #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("fifo count out of range");

	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("fifo pointers disagree with count");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd_en |=> full)
		else $error("fifo left full without a pop");

endmodule

[src/wbc_front.sv]
// ----------------------------------------------------------------------------
// Word-break front end
// Takes items, keeps the recent characters and compares every dictionary
// word against the newest window; queues the end flag and the match vector.
// ----------------------------------------------------------------------------
module wbc_front #(
	parameter int MAX_WORD_LEN = wbc_pkg::MAX_WORD_LEN_DEF,
	parameter int DICT_WORDS   = wbc_pkg::DICT_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                kind,
	input  logic [7:0]          ch,
	input  logic                item_full,
	output logic                item_push,
	output logic [DICT_WORDS:0] item_data
);

	import wbc_pkg::*;

	logic [7:0]            recent_q [MAX_WORD_LEN];
	logic [7:0]            win      [MAX_WORD_LEN];
	logic [DICT_WORDS-1:0] match;
	logic                  xfer;

	assign full      = item_full;
	assign xfer      = push && !item_full;
	assign item_push = xfer;
	// MSB marks an end item
	assign item_data = {kind, match};

	// window with the new character at index 0
	always_comb begin
		win[0] = ch;
		for (int k = 1; k < MAX_WORD_LEN; k++) begin
			win[k] = recent_q[k-1];
		end
	end

	for (genvar w = 0; w < DICT_WORDS; w++) begin : g_word
		localparam int L = word_len(w);
		if (L >= 1 && L <= MAX_WORD_LEN) begin : g_cmp
			logic hit;
			always_comb begin
				hit = 1'b1;
				for (int t = 0; t < L; t++) begin
					if (win[L-1-t] != word_char(w, t)) begin
						hit = 1'b0;
					end
				end
			end
			assign match[w] = hit;
		end else begin : g_none
			assign match[w] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_WORD_LEN; k++) begin
				recent_q[k] <= 8'h00;
			end
		end else if (xfer) begin
			for (int k = 0; k < MAX_WORD_LEN; k++) begin
				recent_q[k] <= kind ? 8'h00 : win[k];
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && kind |=> recent_q[0] == 8'h00)
		else $error("character history not cleared by end item");

	a_char_shift: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !kind |=> recent_q[0] == $past(ch))
		else $error("new character not captured");

	a_push_follow: assert property (@(posedge clk) disable iff (!arst_n)
		item_push == (push && !full))
		else $error("item queue push does not follow input transfer");

endmodule

[src/wbc_back.sv]
// ----------------------------------------------------------------------------
// Word-break back end
// Combines queued match vectors with the prefix flags, updates the flags
// and hands one result per item to the result queue.
// ----------------------------------------------------------------------------
module wbc_back #(
	parameter int MAX_WORD_LEN = wbc_pkg::MAX_WORD_LEN_DEF,
	parameter int DICT_WORDS   = wbc_pkg::DICT_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_empty,
	input  logic [DICT_WORDS:0] item_data,
	output logic                item_pop,
	input  logic                res_full,
	output logic                res_push,
	output wbc_pkg::res_t       res_data
);

	import wbc_pkg::*;

	localparam logic [MAX_WORD_LEN-1:0] HIST_RST = MAX_WORD_LEN'(1);

	// bit k: prefix k+1 characters shorter than the current one splits
	logic [MAX_WORD_LEN-1:0] hist_q;
	logic [MAX_WORD_LEN-1:0] hist_shift;
	logic [DICT_WORDS-1:0]   match;
	logic [DICT_WORDS-1:0]   term;
	logic                    is_end;
	logic                    ok;

	assign is_end   = item_data[DICT_WORDS];
	assign match    = item_data[DICT_WORDS-1:0];
	assign item_pop = !item_empty && !res_full;
	assign res_push = item_pop;

	// a word of length L needs the prefix L characters shorter, held in bit L-1
	for (genvar w = 0; w < DICT_WORDS; w++) begin : g_term
		localparam int L = word_len(w);
		if (L >= 1 && L <= MAX_WORD_LEN) begin : g_use
			assign term[w] = match[w] && hist_q[L-1];
		end else begin : g_none
			assign term[w] = 1'b0;
		end
	end

	assign ok = |term;

	always_comb begin
		hist_shift[0] = ok;
		for (int k = 1; k < MAX_WORD_LEN; k++) begin
			hist_shift[k] = hist_q[k-1];
		end
	end

	always_comb begin
		res_data.at_end     = is_end;
		res_data.splittable = is_end ? hist_q[0] : ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= HIST_RST;
		end else if (item_pop) begin
			hist_q <= is_end ? HIST_RST : hist_shift;
		end
	end

	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop && is_end |=> hist_q == HIST_RST)
		else $error("prefix flags not restored after end item");

	a_flag_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop && !is_end |=> hist_q[0] == $past(res_data.splittable))
		else $error("newest prefix flag differs from reported result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!item_pop |=> $stable(hist_q))
		else $error("prefix flags changed without an item");

endmodule

[src/dictionary_word_break_checker.sv]
// ----------------------------------------------------------------------------
// Dictionary word-break checker
// Streaming check of whether a byte string splits into dictionary words.
// ----------------------------------------------------------------------------
// Push one character per transfer (kind = 0) and one end item (kind = 1) per
// string. Every item yields one result: for a character, whether the prefix
// so far splits into words of the built-in dictionary; for an end item, the
// verdict for the whole string with at_end set, after which the block starts
// over (an empty string answers splittable). The block sustains one item per
// clock in both directions while results are popped; each result passes the
// item queue and the result queue. The rate is set by the prefix flag update
// in the back end; all dictionary words are compared in parallel in the front
// end, and two-entry queues sit between front, back and the result port.
module dictionary_word_break_checker #(
	parameter int MAX_WORD_LEN = wbc_pkg::MAX_WORD_LEN_DEF,
	parameter int DICT_WORDS   = wbc_pkg::DICT_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] ch,
	output logic       empty,
	input  logic       pop,
	output logic       splittable,
	output logic       at_end
);

	import wbc_pkg::*;

	localparam int RES_W = $bits(res_t);

	logic                item_push;
	logic [DICT_WORDS:0] item_wdata;
	logic                item_full;
	logic                item_pop;
	logic [DICT_WORDS:0] item_rdata;
	logic                item_empty;
	logic                res_push;
	res_t                res_wdata;
	logic                res_full;
	logic [RES_W-1:0]    res_rdata;
	res_t                res_out;

	wbc_front #(
		.MAX_WORD_LEN (MAX_WORD_LEN),
		.DICT_WORDS   (DICT_WORDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.ch        (ch),
		.item_full (item_full),
		.item_push (item_push),
		.item_data (item_wdata)
	);

	wbc_fifo #(
		.WIDTH (DICT_WORDS + 1)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_push),
		.wdata  (item_wdata),
		.full   (item_full),
		.pop    (item_pop),
		.rdata  (item_rdata),
		.empty  (item_empty)
	);

	wbc_back #(
		.MAX_WORD_LEN (MAX_WORD_LEN),
		.DICT_WORDS   (DICT_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_empty (item_empty),
		.item_data  (item_rdata),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_wdata)
	);

	wbc_fifo #(
		.WIDTH (RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out    = res_t'(res_rdata);
	assign splittable = res_out.splittable;
	assign at_end     = res_out.at_end;

endmodule
